FILE: hw/rtl/wrs_pkg.sv
`timescale 1ns / 1ps

package wrs_pkg;

  // table size and derived widths
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int W_W         = 8;
  localparam int SUM_W       = $clog2(MAX_ENTRIES * 255 + 1);
  localparam int RW_W        = 31;
  localparam int RWC_W       = $clog2(RW_W + 1);
  localparam int OUT_IDX_W   = 4;
  localparam int STAT_W      = 2;

  // opcodes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SEL = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd3;

  // token that walks down the row of cells
  typedef struct packed {
    logic             go;
    logic [SUM_W-1:0] acc;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
  } tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM_GO,
    S_SUM,
    S_MOD_GO,
    S_MOD,
    S_WALK_GO,
    S_WALK,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/wrs_cell.sv
`timescale 1ns / 1ps

module wrs_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [wrs_pkg::IDX_W-1:0]   cell_idx,
  input  logic [wrs_pkg::CNT_W-1:0]   count,
  input  logic                        wr_en,
  input  logic [wrs_pkg::IDX_W-1:0]   wr_idx,
  input  logic [wrs_pkg::W_W-1:0]     wr_weight,
  input  logic                        walk_mode,
  input  logic [wrs_pkg::SUM_W-1:0]   target,
  input  wrs_pkg::tok_t               tok_in,
  output wrs_pkg::tok_t               tok_out
);

  logic [wrs_pkg::W_W-1:0]   weight_r;
  wrs_pkg::tok_t             tok_r;
  wrs_pkg::tok_t             tok_nxt;
  logic                      live;
  logic [wrs_pkg::SUM_W-1:0] acc_add;

  // only entries below the fill count take part
  assign live    = ({1'b0, cell_idx} < count);
  assign acc_add = tok_in.acc + wrs_pkg::SUM_W'(weight_r);

  always_comb begin
    tok_nxt = tok_in;
    if (live) begin
      tok_nxt.acc = acc_add;
      if (walk_mode && !tok_in.hit && (target <= acc_add)) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_idx = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == cell_idx)) begin
      weight_r <= wr_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.go <= 1'b0;
    end else begin
      tok_r.go <= tok_nxt.go;
    end
    tok_r.acc     <= tok_nxt.acc;
    tok_r.hit     <= tok_nxt.hit;
    tok_r.hit_idx <= tok_nxt.hit_idx;
  end

  assign tok_out = tok_r;

endmodule

FILE: hw/rtl/wrs_mod_unit.sv
`timescale 1ns / 1ps

module wrs_mod_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wrs_pkg::RW_W-1:0]    dividend,
  input  logic [wrs_pkg::SUM_W-1:0]   divisor,
  output logic                        done,
  output logic [wrs_pkg::SUM_W-1:0]   remainder
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [wrs_pkg::RWC_W-1:0]   cnt_r, cnt_nxt;
  logic [wrs_pkg::RW_W-1:0]    dvd_r, dvd_nxt;
  logic [wrs_pkg::SUM_W-1:0]   rem_r, rem_nxt;
  logic [wrs_pkg::SUM_W:0]     trial;
  logic [wrs_pkg::SUM_W:0]     diff;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_r, dvd_r[wrs_pkg::RW_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = wrs_pkg::RWC_W'(wrs_pkg::RW_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[wrs_pkg::SUM_W-1:0]
                                           : trial[wrs_pkg::SUM_W-1:0];
      dvd_nxt = {dvd_r[wrs_pkg::RW_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == wrs_pkg::RWC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/weighted_random_selector.sv
`timescale 1ns / 1ps
// channel  ports                                          direction
// in       in_valid in_ready in_opcode in_entry_weight    request in
//          in_random_word
// out      out_valid out_ready out_selected_index         result out
//          out_status
//
// an add request goes straight to the done state, which loads the result once the output
// slot is free and reopens input as it loads; a select request first runs two passes of a
// token down the row of weight cells (one cell per cycle), summing then walking, with a
// 31-step remainder unit and its start and wait states between them
// empty table and zero-total selects finish early
// rst_n is synchronous, active low; it empties the table and idles the control
// one request at a time; a new request is taken while the previous result waits
// in the output register, and a stalled output holds the finishing request

module weighted_random_selector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [wrs_pkg::W_W-1:0]             in_entry_weight,
  input  logic [wrs_pkg::RW_W-1:0]            in_random_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wrs_pkg::OUT_IDX_W-1:0]       out_selected_index,
  output logic [wrs_pkg::STAT_W-1:0]          out_status
);

  wrs_pkg::state_t state_r, state_nxt;

  logic [wrs_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [wrs_pkg::RW_W-1:0]      rw_r, rw_nxt;
  logic [wrs_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [wrs_pkg::SUM_W-1:0]     target_r, target_nxt;
  logic [wrs_pkg::OUT_IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [wrs_pkg::STAT_W-1:0]    res_stat_r, res_stat_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [wrs_pkg::OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [wrs_pkg::STAT_W-1:0]    out_stat_r, out_stat_nxt;

  logic accept;
  logic full;
  logic empty;
  logic slot_free;
  logic wr_en;
  logic walk_mode;
  logic mod_start;
  logic mod_done;
  logic [wrs_pkg::SUM_W-1:0] mod_rem;

  // token chain: tok[0] is injected by the control, tok[i+1] leaves cell i
  wrs_pkg::tok_t tok [wrs_pkg::MAX_ENTRIES+1];
  wrs_pkg::tok_t tok_head;
  wrs_pkg::tok_t tail;
  logic [wrs_pkg::IDX_W+wrs_pkg::OUT_IDX_W-1:0] idx_ext;

  assign accept    = in_valid && in_ready;
  assign full      = (count_r >= wrs_pkg::CNT_W'(wrs_pkg::MAX_ENTRIES));
  assign empty     = (count_r == '0);
  assign slot_free = !out_valid_r || out_ready;
  assign tok[0]    = tok_head;
  assign tail      = tok[wrs_pkg::MAX_ENTRIES];
  // index wider than the result field keeps its low bits
  assign idx_ext   = {{wrs_pkg::OUT_IDX_W{1'b0}}, tail.hit_idx};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wrs_pkg::S_IDLE: begin
        if (accept) begin
          if (in_opcode == wrs_pkg::OP_ADD || empty) begin
            state_nxt = wrs_pkg::S_DONE;
          end else begin
            state_nxt = wrs_pkg::S_SUM_GO;
          end
        end
      end
      wrs_pkg::S_SUM_GO: state_nxt = wrs_pkg::S_SUM;
      wrs_pkg::S_SUM: begin
        if (tail.go) begin
          state_nxt = (tail.acc == '0) ? wrs_pkg::S_DONE : wrs_pkg::S_MOD_GO;
        end
      end
      wrs_pkg::S_MOD_GO: state_nxt = wrs_pkg::S_MOD;
      wrs_pkg::S_MOD: begin
        if (mod_done) begin
          state_nxt = wrs_pkg::S_WALK_GO;
        end
      end
      wrs_pkg::S_WALK_GO: state_nxt = wrs_pkg::S_WALK;
      wrs_pkg::S_WALK: begin
        if (tail.go) begin
          state_nxt = wrs_pkg::S_DONE;
        end
      end
      wrs_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = wrs_pkg::S_IDLE;
        end
      end
      default: state_nxt = wrs_pkg::S_IDLE;
    endcase
  end

  // control and datapath updates
  always_comb begin
    in_ready      = (state_r == wrs_pkg::S_IDLE);
    wr_en         = 1'b0;
    mod_start     = (state_r == wrs_pkg::S_MOD_GO);
    walk_mode     = (state_r == wrs_pkg::S_WALK_GO) || (state_r == wrs_pkg::S_WALK);
    tok_head.go      = (state_r == wrs_pkg::S_SUM_GO) || (state_r == wrs_pkg::S_WALK_GO);
    tok_head.acc     = '0;
    tok_head.hit     = 1'b0;
    tok_head.hit_idx = '0;
    count_nxt     = count_r;
    rw_nxt        = rw_r;
    sum_nxt       = sum_r;
    target_nxt    = target_r;
    res_idx_nxt   = res_idx_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_stat_nxt  = out_stat_r;

    if (accept) begin
      rw_nxt      = in_random_word;
      res_idx_nxt = '0;
      if (in_opcode == wrs_pkg::OP_ADD) begin
        if (full) begin
          res_stat_nxt = wrs_pkg::ST_FULL;
        end else begin
          wr_en        = 1'b1;
          count_nxt    = count_r + 1'b1;
          res_stat_nxt = wrs_pkg::ST_OK;
        end
      end else if (empty) begin
        res_stat_nxt = wrs_pkg::ST_EMPTY;
      end
    end

    // end of the summing pass
    if (state_r == wrs_pkg::S_SUM && tail.go) begin
      sum_nxt = tail.acc;
      if (tail.acc == '0) begin
        res_idx_nxt  = '0;
        res_stat_nxt = wrs_pkg::ST_ZERO;
      end
    end

    // target = remainder + 1, never above the sum
    if (state_r == wrs_pkg::S_MOD && mod_done) begin
      target_nxt = mod_rem + 1'b1;
    end

    // end of the walk; a miss cannot happen but answers index 0
    if (state_r == wrs_pkg::S_WALK && tail.go) begin
      res_idx_nxt  = tail.hit ? idx_ext[wrs_pkg::OUT_IDX_W-1:0] : '0;
      res_stat_nxt = wrs_pkg::ST_OK;
    end

    if (state_r == wrs_pkg::S_DONE && slot_free) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = res_idx_r;
      out_stat_nxt  = res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrs_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rw_r       <= rw_nxt;
    sum_r      <= sum_nxt;
    target_r   <= target_nxt;
    res_idx_r  <= res_idx_nxt;
    res_stat_r <= res_stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // row of weight cells, one entry each
  genvar gi;
  generate
    for (gi = 0; gi < wrs_pkg::MAX_ENTRIES; gi++) begin : g_cell
      wrs_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_idx  (wrs_pkg::IDX_W'(gi)),
        .count     (count_r),
        .wr_en     (wr_en),
        .wr_idx    (count_r[wrs_pkg::IDX_W-1:0]),
        .wr_weight (in_entry_weight),
        .walk_mode (walk_mode),
        .target    (target_r),
        .tok_in    (tok[gi]),
        .tok_out   (tok[gi+1])
      );
    end
  endgenerate

  wrs_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (rw_r),
    .divisor   (sum_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign out_valid          = out_valid_r;
  assign out_selected_index = out_idx_r;
  assign out_status         = out_stat_r;

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= wrs_pkg::CNT_W'(wrs_pkg::MAX_ENTRIES))
    else $error("entry count above table size");

  // remainder unit finishes only while the control waits for it
  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == wrs_pkg::S_MOD))
    else $error("remainder done outside wait state");

  // a token reaches the end of the row only during a pass
  a_tail_state: assert property (@(posedge clk) disable iff (!rst_n)
    tail.go |-> (state_r == wrs_pkg::S_SUM || state_r == wrs_pkg::S_WALK))
    else $error("stray token at end of row");

  // the walk target lies in 1..sum
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wrs_pkg::S_WALK) |-> (target_r != '0 && target_r <= sum_r))
    else $error("walk target out of range");

endmodule
